// ===== rtl/rmsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared widths and constants for the running mean / std-dev / min / max
// block: default field widths, second moment width and serial unit sizes.
// ----------------------------------------------------------------------------
package rmsd_pkg;

  // default field widths
  localparam int unsigned SAMPLE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF  = 32;

  // second moment accumulator, unsigned, saturating
  localparam int unsigned         M2_BITS = 64;
  localparam logic [M2_BITS-1:0]  M2_MAX  = '1;

  // shared serial divider: up to M2_BITS quotient bits per run
  localparam int unsigned DIV_STEP_BITS = $clog2(M2_BITS + 1);

  // square root unit: one root bit per step, two radicand bits consumed
  localparam int unsigned ROOT_BITS     = M2_BITS / 2;
  localparam int unsigned SQ_REM_BITS   = ROOT_BITS + 2;
  localparam int unsigned SQ_STEP_BITS  = $clog2(ROOT_BITS + 1);

endpackage

// ===== rtl/rmsd_if.sv =====
// ----------------------------------------------------------------------------
// rmsd_in_if / rmsd_out_if
// Valid/ready channels of the statistics block: sample items in, one
// summary item out per series.
// ----------------------------------------------------------------------------
interface rmsd_in_if #(
  parameter int unsigned SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rmsd_out_if #(
  parameter int unsigned SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rmsd_pkg::COUNT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic        [SAMPLE_BITS-1:0] std_dev;
  logic signed [SAMPLE_BITS-1:0] min_value;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic        [COUNT_BITS-1:0]  sample_count;
  logic                          empty_res;

  modport source (output valid, output mean, output std_dev, output min_value,
                  output max_value, output sample_count, output empty_res,
                  input ready);
  modport sink   (input valid, input mean, input std_dev, input min_value,
                  input max_value, input sample_count, input empty_res,
                  output ready);
endinterface

// ===== rtl/running_mean_stddev_min_max.sv =====
// ----------------------------------------------------------------------------
// running_mean_stddev_min_max
// Welford running statistics over a series of signed fixed-point samples.
// Zero samples are skipped. Each nonzero sample updates a saturating count,
// the mean, the saturating second moment, min and max; the item flagged
// last emits mean, population std-dev, min, max, count and an empty flag,
// then clears the series state.
//
//   channel  dir  handshake             payload
//   in_i     in   in_i.valid/ready      sample, last
//   out_o    out  out_o.valid/ready     mean, std_dev, min_value, max_value,
//                                       sample_count, empty_res
//
// One item at a time; in_i.ready is high only while idle.
// Zero sample: captured and checked, then skipped. Nonzero sample: the
// bit-serial divide for the mean, then the 2-bit-per-cycle multiply for
// the second moment.
// Last item adds a 64-step divide of M2 by count, then a 32-step square
// root. The result waits in an output register; a later last item stalls
// only if that register is still full when its result is ready.
// Asynchronous active-low reset clears the series and the output valid flag.
// ----------------------------------------------------------------------------
module running_mean_stddev_min_max #(
  parameter int unsigned SAMPLE_BITS = rmsd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rmsd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmsd_in_if.sink     in_i,
  rmsd_out_if.source  out_o
);
  import rmsd_pkg::*;

  localparam int unsigned AW  = SAMPLE_BITS + 1;
  localparam int unsigned AWM = AW + (AW % 2);
  localparam int unsigned PW  = 2 * AWM;
  localparam int unsigned XW  = (PW > M2_BITS) ? PW : M2_BITS;
  localparam int unsigned RW  = (ROOT_BITS > SAMPLE_BITS) ? ROOT_BITS : SAMPLE_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_BDIF  = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_FDIV  = 4'd5;
  localparam logic [3:0] ST_FWAIT = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]                    state_q, state_d;

  // series state
  logic [COUNT_BITS-1:0]         count_q;
  logic signed [SAMPLE_BITS-1:0] mean_q;
  logic [M2_BITS-1:0]            m2_q;
  logic signed [SAMPLE_BITS-1:0] min_q;
  logic signed [SAMPLE_BITS-1:0] max_q;

  // per-item working registers
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          last_q;
  logic [AW-1:0]                 a_q;
  logic                          neg_q;
  logic [SAMPLE_BITS-1:0]        sd_q;

  // output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_mean_q;
  logic [SAMPLE_BITS-1:0]        out_sd_q;
  logic signed [SAMPLE_BITS-1:0] out_min_q;
  logic signed [SAMPLE_BITS-1:0] out_max_q;
  logic [COUNT_BITS-1:0]         out_count_q;
  logic                          out_empty_q;

  logic                          in_accept;
  logic                          out_load;
  logic                          series_empty;
  logic [AW-1:0]                 d_full;
  logic [AW-1:0]                 a_d;
  logic [COUNT_BITS-1:0]         cnt_inc;

  logic                          div_start;
  logic [M2_BITS-1:0]            div_dvd;
  logic [COUNT_BITS-1:0]         div_dsr;
  logic [DIV_STEP_BITS-1:0]      div_steps;
  logic                          div_done;
  logic [M2_BITS-1:0]            div_quot;

  logic [SAMPLE_BITS+1:0]        mean_ext;
  logic [SAMPLE_BITS+1:0]        q_ext;
  logic [SAMPLE_BITS+1:0]        nm_full;

  logic                          mul_start;
  logic                          mul_done;
  logic [PW-1:0]                 mul_prod;
  logic [XW-1:0]                 prod_ext;
  logic [M2_BITS-1:0]            prod_sat;
  logic [M2_BITS:0]              m2_sum;
  logic [M2_BITS-1:0]            m2_nx;

  logic                          sqrt_start;
  logic                          sqrt_done;
  logic [ROOT_BITS-1:0]          root;
  logic [RW-1:0]                 root_ext;
  logic [SAMPLE_BITS-1:0]        sd_sat;

  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_accept    = in_i.valid && in_i.ready;
  assign series_empty = (count_q == '0);
  assign out_load     = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // deviation from the mean and its magnitude (b reuses this after the mean moves)
  always_comb begin
    d_full  = {x_q[SAMPLE_BITS-1], x_q} - {mean_q[SAMPLE_BITS-1], mean_q};
    a_d     = d_full[AW-1] ? (AW'(0) - d_full) : d_full;
    cnt_inc = (count_q == '1) ? count_q : count_q + 1'b1;
  end

  // divider operand select: mean step or final variance
  always_comb begin
    div_start = ((state_q == ST_PREP) && (x_q != '0))
             || ((state_q == ST_FDIV) && !series_empty);
    if (state_q == ST_PREP) begin
      div_dvd   = {a_d, {(M2_BITS-AW){1'b0}}};
      div_dsr   = cnt_inc;
      div_steps = DIV_STEP_BITS'(AW);
    end else begin
      div_dvd   = m2_q;
      div_dsr   = count_q;
      div_steps = DIV_STEP_BITS'(M2_BITS);
    end
  end

  // new mean, quotient truncated toward zero
  always_comb begin
    mean_ext = {{2{mean_q[SAMPLE_BITS-1]}}, mean_q};
    q_ext    = {1'b0, div_quot[AW-1:0]};
    nm_full  = neg_q ? (mean_ext - q_ext) : (mean_ext + q_ext);
  end

  // saturating second moment update
  always_comb begin
    mul_start = (state_q == ST_BDIF);
    prod_ext  = XW'(mul_prod);
    prod_sat  = (prod_ext > XW'(M2_MAX)) ? M2_MAX : prod_ext[M2_BITS-1:0];
    m2_sum    = {1'b0, m2_q} + {1'b0, prod_sat};
    m2_nx     = m2_sum[M2_BITS] ? M2_MAX : m2_sum[M2_BITS-1:0];
  end

  // square root start and clamp to the sample width
  always_comb begin
    sqrt_start = (state_q == ST_FWAIT) && div_done;
    root_ext   = RW'(root);
    sd_sat     = (root_ext > RW'({SAMPLE_BITS{1'b1}})) ? {SAMPLE_BITS{1'b1}}
                                                       : root_ext[SAMPLE_BITS-1:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_PREP;
      ST_PREP: begin
        if (x_q != '0)  state_d = ST_DIV;
        else if (last_q) state_d = ST_FDIV;
        else            state_d = ST_IDLE;
      end
      ST_DIV:   if (div_done) state_d = ST_BDIF;
      ST_BDIF:  state_d = ST_MUL;
      ST_MUL:   if (mul_done) state_d = last_q ? ST_FDIV : ST_IDLE;
      ST_FDIV:  state_d = series_empty ? ST_OUT : ST_FWAIT;
      ST_FWAIT: if (div_done) state_d = ST_SQRT;
      ST_SQRT:  if (sqrt_done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control and series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      min_q       <= SMAX;
      max_q       <= SMIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_PREP) && (x_q != '0)) begin
        count_q <= cnt_inc;
        if (x_q < min_q) min_q <= x_q;
        if (x_q > max_q) max_q <= x_q;
      end
      if ((state_q == ST_DIV) && div_done) begin
        mean_q <= nm_full[SAMPLE_BITS-1:0];
      end
      if ((state_q == ST_MUL) && mul_done) begin
        m2_q <= m2_nx;
      end
      if (out_load) begin
        count_q <= '0;
        mean_q  <= '0;
        m2_q    <= '0;
        min_q   <= SMAX;
        max_q   <= SMIN;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q    <= in_i.sample;
      last_q <= in_i.last;
    end
    if (state_q == ST_PREP) begin
      a_q   <= a_d;
      neg_q <= d_full[AW-1];
    end
    if ((state_q == ST_SQRT) && sqrt_done) begin
      sd_q <= sd_sat;
    end
    if (out_load) begin
      out_empty_q <= series_empty;
      out_count_q <= count_q;
      out_mean_q  <= series_empty ? '0 : mean_q;
      out_sd_q    <= series_empty ? '0 : sd_q;
      out_min_q   <= series_empty ? '0 : min_q;
      out_max_q   <= series_empty ? '0 : max_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mean         = out_mean_q;
  assign out_o.std_dev      = out_sd_q;
  assign out_o.min_value    = out_min_q;
  assign out_o.max_value    = out_max_q;
  assign out_o.sample_count = out_count_q;
  assign out_o.empty_res    = out_empty_q;

  // shared serial divider
  rmsd_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // |d| * |x - mean'|
  rmsd_mul #(
    .OP_BITS (AWM)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (AWM'(a_q)),
    .b_i       (AWM'(a_d)),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  // std-dev from M2 / count
  rmsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quot),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // min never above max once a sample is counted
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (min_q <= max_q))
    else $error("min above max with nonzero count");

  // the running mean stays inside the seen range between items
  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_IDLE) && (count_q != '0)) |-> ((min_q <= mean_q) && (mean_q <= max_q)))
    else $error("mean outside min/max");

  // count only grows or holds within a series
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_OUT) |=> (count_q >= $past(count_q)))
    else $error("count dropped inside a series");

  // divider completes only where the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> ((state_q == ST_DIV) || (state_q == ST_FWAIT)))
    else $error("divider done in unexpected state");

  // an empty result carries a zero count
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.empty_res) |-> (out_o.sample_count == '0))
    else $error("empty result with nonzero count");

endmodule

// ===== rtl/rmsd_div.sv =====
// ----------------------------------------------------------------------------
// rmsd_div
// Restoring radix-2 divider, one quotient bit per cycle. The dividend is
// left aligned and shifted out MSB first; quotient bits shift in at the
// bottom, so after N steps the low N bits hold the quotient.
// ----------------------------------------------------------------------------
module rmsd_div #(
  parameter int unsigned COUNT_BITS = rmsd_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [rmsd_pkg::M2_BITS-1:0]         dividend_i,
  input  logic [COUNT_BITS-1:0]                divisor_i,
  input  logic [rmsd_pkg::DIV_STEP_BITS-1:0]   steps_i,
  output logic                                 done_o,
  output logic [rmsd_pkg::M2_BITS-1:0]         quotient_o
);
  import rmsd_pkg::*;

  logic [M2_BITS-1:0]       dvd_q;
  logic [COUNT_BITS-1:0]    rem_q;
  logic [COUNT_BITS-1:0]    dsr_q;
  logic [DIV_STEP_BITS-1:0] cnt_q;
  logic                     done_q;

  logic [COUNT_BITS:0]      shifted;
  logic [COUNT_BITS:0]      diff;
  logic                     ge;
  logic [COUNT_BITS-1:0]    rem_d;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, dvd_q[M2_BITS-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = (shifted >= {1'b0, dsr_q});
    rem_d   = ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= steps_i;
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == DIV_STEP_BITS'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      dvd_q <= {dvd_q[M2_BITS-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== rtl/rmsd_mul.sv =====
// ----------------------------------------------------------------------------
// rmsd_mul
// Unsigned shift-add multiplier, two multiplier bits per cycle. The
// multiplier sits in the low half of the product register and is shifted
// out as partial products accumulate in the high half.
// ----------------------------------------------------------------------------
module rmsd_mul #(
  parameter int unsigned OP_BITS = 34
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [OP_BITS-1:0]     a_i,
  input  logic [OP_BITS-1:0]     b_i,
  output logic                   done_o,
  output logic [2*OP_BITS-1:0]   product_o
);
  import rmsd_pkg::*;

  localparam int unsigned STEPS = OP_BITS / 2;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [2*OP_BITS-1:0] p_q;
  logic [OP_BITS-1:0]   b_q;
  logic [CW-1:0]        cnt_q;
  logic                 done_q;

  logic [OP_BITS+1:0]   pp;
  logic [OP_BITS+1:0]   sum;

  // partial product for one radix-4 digit, added to the upper half
  always_comb begin
    pp  = ({2'b00, b_q} & {(OP_BITS+2){p_q[0]}})
        + ({1'b0, b_q, 1'b0} & {(OP_BITS+2){p_q[1]}});
    sum = {2'b00, p_q[2*OP_BITS-1:OP_BITS]} + pp;
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{OP_BITS{1'b0}}, a_i};
      b_q <= b_i;
    end else if (cnt_q != '0) begin
      p_q <= {sum, p_q[OP_BITS-1:2]};
    end
  end

  assign done_o    = done_q;
  assign product_o = p_q;

endmodule

// ===== rtl/rmsd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmsd_sqrt
// Digit-by-digit integer square root: two radicand bits in and one root
// bit out per cycle, floor result after ROOT_BITS steps.
// ----------------------------------------------------------------------------
module rmsd_sqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rmsd_pkg::M2_BITS-1:0]      radicand_i,
  output logic                              done_o,
  output logic [rmsd_pkg::ROOT_BITS-1:0]    root_o
);
  import rmsd_pkg::*;

  logic [M2_BITS-1:0]      rad_q;
  logic [SQ_REM_BITS-1:0]  rem_q;
  logic [ROOT_BITS-1:0]    root_q;
  logic [SQ_STEP_BITS-1:0] cnt_q;
  logic                    done_q;

  logic [SQ_REM_BITS+1:0]  sh;
  logic [SQ_REM_BITS+1:0]  trial;
  logic [SQ_REM_BITS+1:0]  diff;
  logic                    ge;

  // trial subtract of 4*root + 1
  always_comb begin
    sh    = {rem_q, rad_q[M2_BITS-1:M2_BITS-2]};
    trial = {2'b00, root_q, 2'b01};
    diff  = sh - trial;
    ge    = (sh >= trial);
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= SQ_STEP_BITS'(ROOT_BITS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == SQ_STEP_BITS'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // radicand, remainder and root registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[M2_BITS-3:0], 2'b00};
      rem_q  <= ge ? diff[SQ_REM_BITS-1:0] : sh[SQ_REM_BITS-1:0];
      root_q <= {root_q[ROOT_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== sim/tb_running_mean_stddev_min_max.sv =====
// ----------------------------------------------------------------------------
// tb_running_mean_stddev_min_max
// Self-checking bench for the running mean / std-dev / min / max block.
// A scoreboard predicts every series summary from the accepted sample
// items and compares each emitted summary field by field, in order.
// Directed series hit the empty, single-sample and saturation cases, then
// random series of clustered, full-range and zero samples follow under
// bursty input traffic and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_running_mean_stddev_min_max;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SW       = rmsd_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned CW       = rmsd_pkg::COUNT_BITS_DEF;
  localparam int unsigned N_ITEMS  = 950;
  localparam int unsigned LIMIT    = 1_000_000;
  localparam int unsigned TAIL_CYC = 200;

  typedef struct {
    logic signed [SW-1:0] mean;
    logic [SW-1:0]        std_dev;
    logic signed [SW-1:0] min_value;
    logic signed [SW-1:0] max_value;
    logic [CW-1:0]        sample_count;
    logic                 empty_res;
  } stats_summary_t;

  // series statistics predictor plus queue of summaries still owed
  class stats_scoreboard;
    int unsigned    errors;
    logic [CW-1:0]  n_seen;
    longint         run_mean;
    logic [63:0]    m2_acc;
    longint         lo_seen;
    longint         hi_seen;
    stats_summary_t owed_q[$];

    function new();
      errors = 0;
      clear_series();
    endfunction

    function void clear_series();
      n_seen   = '0;
      run_mean = 0;
      m2_acc   = '0;
      lo_seen  = (longint'(1) <<< (SW - 1)) - 1;
      hi_seen  = -(longint'(1) <<< (SW - 1));
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] summary mismatch on %s: got %h, want %h", $realtime, what, got, want);
      errors++;
    endfunction

    // fold one accepted item into the series, queue a summary on last
    function void note_input(logic signed [SW-1:0] smp, logic lst);
      longint         x;
      longint         diff;
      longint         dev;
      longint         next_mean;
      logic [63:0]    dmag;
      logic [63:0]    devmag;
      logic [63:0]    step;
      logic [63:0]    prod_sat;
      logic [63:0]    var_q;
      logic [63:0]    root;
      logic [63:0]    trial;
      logic [127:0]   prod;
      logic [64:0]    sum;
      stats_summary_t res;
      x = longint'(smp);
      if (x != 0) begin
        if (n_seen != {CW{1'b1}}) n_seen++;
        diff      = x - run_mean;
        dmag      = (diff < 0) ? 64'(-diff) : 64'(diff);
        step      = dmag / 64'(n_seen);
        next_mean = (diff < 0) ? run_mean - longint'(step) : run_mean + longint'(step);
        dev       = x - next_mean;
        devmag    = (dev < 0) ? 64'(-dev) : 64'(dev);
        // second moment update, saturating on product and on sum
        prod      = 128'(dmag) * 128'(devmag);
        prod_sat  = (prod[127:64] != '0) ? '1 : prod[63:0];
        sum       = 65'(m2_acc) + 65'(prod_sat);
        m2_acc    = sum[64] ? '1 : sum[63:0];
        run_mean  = next_mean;
        if (x < lo_seen) lo_seen = x;
        if (x > hi_seen) hi_seen = x;
      end
      if (!lst) return;
      res = '{default: '0};
      if (n_seen == '0) begin
        res.empty_res = 1'b1;
      end else begin
        // integer square root of M2 / count, one root bit at a time
        var_q = m2_acc / 64'(n_seen);
        root  = '0;
        for (int b = 31; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= var_q) root = trial;
        end
        if (SW < 64 && (root >> SW) != '0) root = (64'd1 << SW) - 1;
        res.mean         = run_mean[SW-1:0];
        res.std_dev      = root[SW-1:0];
        res.min_value    = lo_seen[SW-1:0];
        res.max_value    = hi_seen[SW-1:0];
        res.sample_count = n_seen;
        res.empty_res    = 1'b0;
      end
      owed_q.insert(owed_q.size(), res);
      clear_series();
    endfunction

    // compare an emitted summary against the oldest one owed
    function void check_result(stats_summary_t got);
      stats_summary_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("unexpected summary, mean", 64'(got.mean), '0);
        return;
      end
      want = owed_q.pop_front();
      if (got.mean !== want.mean)
        report_mismatch("mean", 64'(got.mean), 64'(want.mean));
      if (got.std_dev !== want.std_dev)
        report_mismatch("std_dev", 64'(got.std_dev), 64'(want.std_dev));
      if (got.min_value !== want.min_value)
        report_mismatch("min_value", 64'(got.min_value), 64'(want.min_value));
      if (got.max_value !== want.max_value)
        report_mismatch("max_value", 64'(got.max_value), 64'(want.max_value));
      if (got.sample_count !== want.sample_count)
        report_mismatch("sample_count", 64'(got.sample_count), 64'(want.sample_count));
      if (got.empty_res !== want.empty_res)
        report_mismatch("empty_res", 64'(got.empty_res), 64'(want.empty_res));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rmsd_in_if  #(.SAMPLE_BITS(SW))                  in_if ();
  rmsd_out_if #(.SAMPLE_BITS(SW), .COUNT_BITS(CW)) out_if ();

  running_mean_stddev_min_max #(
    .SAMPLE_BITS(SW),
    .COUNT_BITS (CW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  stats_scoreboard sb = new();
  stats_summary_t  seen_res;
  int unsigned     cycle_cnt  = 0;
  int unsigned     burst_left = 0;
  int unsigned     rx_left    = 0;
  int unsigned     rx_mode    = 0;
  int unsigned     rx_period  = 2;
  int unsigned     rx_tick    = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        seen_res.mean         = out_if.mean;
        seen_res.std_dev      = out_if.std_dev;
        seen_res.min_value    = out_if.min_value;
        seen_res.max_value    = out_if.max_value;
        seen_res.sample_count = out_if.sample_count;
        seen_res.empty_res    = out_if.empty_res;
        sb.check_result(seen_res);
      end
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.sample, in_if.last);
    end
  end

  // output stall pattern, switching among four random modes
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      rx_left   = $urandom_range(50, 400);
      rx_period = $urandom_range(2, 9);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 9) < 7);
      2: out_if.ready <= ((rx_tick % rx_period) == 0);
      default: out_if.ready <= ((rx_tick % 64) >= 48);
    endcase
  end

  // hold the input channel idle, scrambling the payload meanwhile
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid  <= 1'b0;
      in_if.sample <= $urandom;
      in_if.last   <= $urandom_range(0, 1);
    end
  endtask

  // offer one item, with bursty gaps in front, and wait for acceptance
  task automatic send_item(input logic [SW-1:0] smp, input logic lst);
    int unsigned pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 3);
      if (pick == 1)      idle_cycles($urandom_range(1, 8));
      else if (pick == 2) idle_cycles($urandom_range(1, 8));
      else if (pick == 3) idle_cycles($urandom_range(20, 90));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid  <= 1'b1;
    in_if.sample <= smp;
    in_if.last   <= lst;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // stop sending until every owed summary has come out
  task automatic wait_drained();
    idle_cycles(1);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // stimulus
  initial begin
    int unsigned    counted;
    int unsigned    ser_len;
    int unsigned    pick;
    int unsigned    spread;
    logic [SW-1:0]  base;
    logic [SW-1:0]  smp;
    logic           lst;
    logic           all_zero;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.last   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty series closed by a zero sample
    send_item('0, 1'b1);
    // single samples at both ends of the range
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b1);
    // leading zero is skipped, zero on last still closes the series
    send_item('0, 1'b0);
    send_item(32'h0001_8000, 1'b0);
    send_item(32'hFFFF_0000, 1'b0);
    send_item('0, 1'b1);
    // series of zeros only
    send_item('0, 1'b0);
    send_item('0, 1'b0);
    send_item('0, 1'b1);
    // full-scale alternation saturates the second moment
    for (int i = 0; i < 8; i++)
      send_item((i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 7);
    // smallest magnitudes, nonzero sample on last
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hFFFF_FFFE, 1'b1);
    wait_drained();

    // random series
    counted = 0;
    while (counted < N_ITEMS) begin
      ser_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      all_zero = ($urandom_range(0, 24) == 0);
      base     = $urandom;
      spread   = 32'd1 << $urandom_range(0, 24);
      for (int k = 0; k < ser_len; k++) begin
        pick = $urandom_range(0, 19);
        if (all_zero || pick == 4 || pick == 5) begin
          smp = '0;
        end else if (pick < 3) begin
          smp = $urandom;
        end else if (pick == 3) begin
          case ($urandom_range(0, 3))
            0: smp = 32'h7FFF_FFFF;
            1: smp = 32'h8000_0000;
            2: smp = 32'h0000_0001;
            default: smp = 32'hFFFF_FFFF;
          endcase
        end else if (pick < 8) begin
          smp = $urandom_range(1, 65535);
          if ($urandom_range(0, 1)) smp = -smp;
        end else begin
          smp = base + $urandom_range(0, spread) - (spread >> 1);
        end
        lst = (k == ser_len - 1);
        send_item(smp, lst);
        counted++;
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end

    // drain and let the block settle
    wait_drained();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
